// ----- design/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers used by the checker file twc_checker.sv
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define AST_IMPL(label, clk, dis, ante, cons) \
  label: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define AST_NEXT(label, clk, dis, ante, cons) \
  label: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- design/twc_pkg.sv -----
// ----------------------------------------------------------------------------
// twc_pkg
// types, constants and lookup functions for the trigger window counter
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package twc_pkg;

  localparam int TW      = 14;  // time shift width
  localparam int PREW    = 10;
  localparam int POSTW   = 14;
  localparam int PHW     = 7;
  localparam int RECIPW  = 20;  // reciprocal fraction bits
  localparam int STEPW   = 7;
  localparam int CFG_AW  = 4;
  localparam int CFG_DW  = 32;

  typedef enum logic [1:0] {
    REG_MODE = 2'd0,
    REG_POS  = 2'd1,
    REG_TB   = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic       mode;
    logic [1:0] pos;
    logic [2:0] tb;
  } cfg_t;

  typedef struct packed {
    logic [PHW-1:0]   phase;
    logic [POSTW-1:0] post;
    logic [PREW-1:0]  pre;
  } result_t;

  // real-time trigger offset
  function automatic logic [8:0] k_real(input logic [1:0] pos);
    logic [8:0] k;
    case (pos)
      2'd0:    k = 9'd0;
      2'd1:    k = 9'd250;
      default: k = 9'd500;
    endcase
    return k;
  endfunction

  function automatic logic [STEPW-1:0] step_of(input logic [2:0] tb);
    logic [STEPW-1:0] s;
    case (tb)
      3'd0:    s = 7'd100;
      3'd1:    s = 7'd50;
      3'd2:    s = 7'd20;
      3'd3:    s = 7'd10;
      3'd4:    s = 7'd5;
      default: s = 7'd2;
    endcase
    return s;
  endfunction

  // floor(2^20 / step), quotient estimate is low by at most one
  function automatic logic [RECIPW-1:0] recip_of(input logic [2:0] tb);
    logic [RECIPW-1:0] m;
    case (tb)
      3'd0:    m = 20'd10485;
      3'd1:    m = 20'd20971;
      3'd2:    m = 20'd52428;
      3'd3:    m = 20'd104857;
      3'd4:    m = 20'd209715;
      default: m = 20'd524288;
    endcase
    return m;
  endfunction

  // 512 / step
  function automatic logic [8:0] half_of(input logic [2:0] tb);
    logic [8:0] h;
    case (tb)
      3'd0:    h = 9'd5;
      3'd1:    h = 9'd10;
      3'd2:    h = 9'd25;
      3'd3:    h = 9'd51;
      3'd4:    h = 9'd102;
      default: h = 9'd256;
    endcase
    return h;
  endfunction

  // randomized trigger offset; position three acts as right
  function automatic logic [7:0] k_rand(input logic [2:0] tb, input logic [1:0] pos);
    logic [7:0] mid;
    logic [7:0] right;
    logic [7:0] k;
    case (tb)
      3'd0:    begin mid = 8'h03; right = 8'h05; end
      3'd1:    begin mid = 8'h05; right = 8'h0a; end
      3'd2:    begin mid = 8'h0d; right = 8'h19; end
      3'd3:    begin mid = 8'h19; right = 8'h32; end
      3'd4:    begin mid = 8'h32; right = 8'h64; end
      default: begin mid = 8'h7d; right = 8'hfa; end
    endcase
    case (pos)
      2'd0:    k = 8'd0;
      2'd1:    k = mid;
      default: k = right;
    endcase
    return k;
  endfunction

endpackage

// ----- design/twc_calc.sv -----
// ----------------------------------------------------------------------------
// twc_calc
// quotient correction, remainder and count clamping for one shift value
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module twc_calc (
  input  logic [twc_pkg::TW-1:0]  t,
  input  logic [twc_pkg::TW-1:0]  q_est,
  input  twc_pkg::cfg_t           cfg,
  input  logic [twc_pkg::PHW-1:0] held,
  output twc_pkg::result_t        res,
  output logic [twc_pkg::PHW-1:0] held_nxt
);

  logic [twc_pkg::STEPW-1:0]            s;
  logic [twc_pkg::TW+twc_pkg::STEPW-1:0] qs;
  logic [twc_pkg::TW+twc_pkg::STEPW-1:0] r_full;
  logic [7:0]                           r;
  logic [7:0]                           r_fix;
  logic [twc_pkg::TW-1:0]               q;
  logic signed [15:0]                   ts;
  logic signed [15:0]                   kr;
  logic signed [15:0]                   pre_v;
  logic signed [15:0]                   c;
  logic signed [15:0]                   post_v;
  logic signed [15:0]                   m;
  logic signed [15:0]                   d;
  logic signed [15:0]                   pre_rt;
  logic signed [15:0]                   post_rt;
  logic signed [15:0]                   pre_rd;
  logic signed [15:0]                   post_rd;

  always_comb begin
    s      = twc_pkg::step_of(cfg.tb);
    qs     = q_est * s;
    r_full = {{twc_pkg::STEPW{1'b0}}, t} - qs;
    r      = r_full[7:0];
    // estimate can be one low
    if (r >= {1'b0, s}) begin
      q     = q_est + 14'd1;
      r_fix = r - {1'b0, s};
    end else begin
      q     = q_est;
      r_fix = r;
    end

    ts = $signed({2'b00, t});
    kr = $signed({7'b0, twc_pkg::k_real(cfg.pos)});

    // real-time counts
    pre_v = kr - ts + 16'sd511;
    if (pre_v < 16'sd1) pre_rt = 16'sd1;
    else if (pre_v > 16'sd500) pre_rt = 16'sd500;
    else pre_rt = pre_v;
    c = ts - kr + 16'sd10;
    if (c < 16'sd10) c = 16'sd10;
    else if (c > 16'sd16383) c = 16'sd16383;
    post_v = 16'sd16383 - c;
    post_rt = (post_v <= 16'sd0) ? 16'sd1 : post_v;

    // randomized counts
    m = $signed({8'b0, twc_pkg::k_rand(cfg.tb, cfg.pos)}) - $signed({2'b00, q})
        + $signed({7'b0, twc_pkg::half_of(cfg.tb)});
    d = 16'sd511 - m;
    if (d < 16'sd10) d = 16'sd10;
    else if (d > 16'sd16383) d = 16'sd16383;
    post_v = 16'sd16381 - d;
    post_rd = (post_v <= 16'sd0) ? 16'sd1 : post_v;
    if (m < 16'sd1) pre_rd = 16'sd1;
    else if (m > 16'sd512) pre_rd = 16'sd512;
    else pre_rd = m;

    if (cfg.mode) begin
      held_nxt = r_fix[twc_pkg::PHW-1:0];
      res.pre  = pre_rd[twc_pkg::PREW-1:0];
      res.post = post_rd[twc_pkg::POSTW-1:0];
    end else begin
      held_nxt = held;
      res.pre  = pre_rt[twc_pkg::PREW-1:0];
      res.post = post_rt[twc_pkg::POSTW-1:0];
    end
    res.phase = held_nxt;
  end

endmodule

// ----- design/trigger_window_counts_top.sv -----
// throughput: one item per cycle unless out_tready stalls the output; the
// stages are input register, reciprocal multiply register and result
// register, each with its own ready
// a stall on the output fills empty stages before in_tready drops
// reset: synchronous active-low rst_n clears valids, config and held phase
// ----------------------------------------------------------------------------
// trigger_window_counts_top
// pre/post trigger count generator with apb config and stream ports
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module trigger_window_counts_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [15:0]                   in_tdata,   // [13:0] time_shift
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [31:0]                   out_tdata,  // [9:0] pre_count, [23:10] post_count,
                                                    // [30:24] phase_offset
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [twc_pkg::CFG_AW-1:0]    cfg_paddr,
  input  logic [twc_pkg::CFG_DW-1:0]    cfg_pwdata,
  output logic [twc_pkg::CFG_DW-1:0]    cfg_prdata,
  output logic                          cfg_pready
);

  twc_pkg::cfg_t                    cfg_r;
  logic [1:0]                       cfg_idx;
  logic                             cfg_wr;

  logic                             a_valid_r;
  logic [twc_pkg::TW-1:0]           t_a_r;
  logic                             b_valid_r;
  logic [twc_pkg::TW-1:0]           t_b_r;
  logic [twc_pkg::TW-1:0]           q_b_r;
  logic                             out_valid_r;
  twc_pkg::result_t                 out_r;
  logic [twc_pkg::PHW-1:0]          held_r;

  logic [twc_pkg::TW+twc_pkg::RECIPW-1:0] prod;
  logic [twc_pkg::TW-1:0]           q_nxt;
  twc_pkg::result_t                 res_nxt;
  logic [twc_pkg::PHW-1:0]          held_nxt;
  logic                             out_rdy;
  logic                             b_rdy;
  logic                             a_rdy;

  // configuration port
  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[3:2];
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_comb begin
    case (cfg_idx)
      twc_pkg::REG_MODE: cfg_prdata = {31'b0, cfg_r.mode};
      twc_pkg::REG_POS:  cfg_prdata = {30'b0, cfg_r.pos};
      twc_pkg::REG_TB:   cfg_prdata = {29'b0, cfg_r.tb};
      default:           cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        twc_pkg::REG_MODE: cfg_r.mode <= cfg_pwdata[0];
        twc_pkg::REG_POS:  cfg_r.pos  <= cfg_pwdata[1:0];
        twc_pkg::REG_TB:   cfg_r.tb   <= cfg_pwdata[2:0];
        default: ;
      endcase
    end
  end

  // stage handshakes
  assign out_rdy   = !out_valid_r || out_tready;
  assign b_rdy     = !b_valid_r || out_rdy;
  assign a_rdy     = !a_valid_r || b_rdy;
  assign in_tready = a_rdy;

  // quotient estimate by reciprocal multiply
  assign prod  = t_a_r * twc_pkg::recip_of(cfg_r.tb);
  assign q_nxt = prod[twc_pkg::TW+twc_pkg::RECIPW-1:twc_pkg::RECIPW];

  twc_calc u_calc (
    .t        (t_b_r),
    .q_est    (q_b_r),
    .cfg      (cfg_r),
    .held     (held_r),
    .res      (res_nxt),
    .held_nxt (held_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r   <= 1'b0;
      b_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
      held_r      <= '0;
    end else begin
      if (a_rdy) begin
        a_valid_r <= in_tvalid;
      end
      if (b_rdy) begin
        b_valid_r <= a_valid_r;
      end
      if (out_rdy) begin
        out_valid_r <= b_valid_r;
        if (b_valid_r) begin
          held_r <= held_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (a_rdy && in_tvalid) begin
      t_a_r <= in_tdata[twc_pkg::TW-1:0];
    end
    if (b_rdy && a_valid_r) begin
      t_b_r <= t_a_r;
      q_b_r <= q_nxt;
    end
    if (out_rdy && b_valid_r) begin
      out_r <= res_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_r};

endmodule

// ----- design/twc_checker.sv -----
// ----------------------------------------------------------------------------
// twc_checker
// port-level checks on the result stream of the trigger window counter
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module twc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata
);

  `AST_NEXT(a_reset_idle, clk, 1'b0, !rst_n, !out_tvalid)
  `AST_NEXT(a_out_hold, clk, !rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))
  `AST_IMPL(a_pre_range, clk, !rst_n, out_tvalid, out_tdata[9:0] != 10'd0 && out_tdata[9:0] <= 10'd512)
  `AST_IMPL(a_post_range, clk, !rst_n, out_tvalid, out_tdata[23:10] != 14'd0 && out_tdata[23:10] <= 14'd16373)
  `AST_IMPL(a_phase_range, clk, !rst_n, out_tvalid, out_tdata[30:24] <= 7'd99 && !out_tdata[31])

endmodule

bind trigger_window_counts_top twc_checker u_twc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// ----- verif/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the trigger window counter: apb setup of the
// acquisition mode, trigger position and timebase, stream of time shifts in,
// pre/post counts and phase offset out, compared against a local model
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

  localparam logic [1:0] REG_UNUSED   = 2'd3;  // decodes to no register
  localparam logic       ACQ_REALTIME = 1'b0;
  localparam logic       ACQ_RANDOM   = 1'b1;
  localparam int         STALL_LIMIT  = 1000;
  localparam int         HOLD_CYCLES  = 80;
  localparam int         SEGMENTS     = 9;
  localparam int         SEG_ITEMS    = 195;

  localparam int REAL_OFFSET [3]    = '{0, 250, 500};
  localparam int RAND_STEP   [6]    = '{100, 50, 20, 10, 5, 2};
  localparam int RAND_OFFSET [6][3] = '{'{0, 3, 5}, '{0, 5, 10}, '{0, 13, 25},
                                        '{0, 25, 50}, '{0, 50, 100}, '{0, 125, 250}};

  typedef struct packed {
    bit        mode;
    bit [1:0]  pos;
    bit [2:0]  tb;
    bit [13:0] shift;
    bit        typed;   // counts below hold the expected result
    bit [9:0]  pre;
    bit [13:0] post;
    bit [6:0]  phase;
  } shift_row_t;

  // mode, position, timebase, shift, typed, pre, post, phase
  localparam shift_row_t SHIFT_ROWS [22] = '{
    '{0, 0, 0, 0,     1, 500, 16373, 0},
    '{0, 0, 0, 16383, 1, 1,   1,     0},
    '{0, 0, 0, 510,   0, 0, 0, 0},
    '{0, 1, 0, 0,     0, 0, 0, 0},
    '{0, 1, 0, 760,   0, 0, 0, 0},
    '{0, 2, 0, 1011,  0, 0, 0, 0},
    '{0, 3, 0, 490,   0, 0, 0, 0},
    '{0, 2, 0, 16383, 0, 0, 0, 0},
    '{1, 0, 0, 0,     0, 0, 0, 0},
    '{1, 0, 0, 16383, 0, 0, 0, 0},
    '{1, 1, 0, 99,    0, 0, 0, 0},
    '{1, 2, 1, 12345, 0, 0, 0, 0},
    '{1, 1, 2, 7777,  0, 0, 0, 0},
    '{1, 2, 3, 5000,  0, 0, 0, 0},
    '{1, 0, 4, 16383, 0, 0, 0, 0},
    '{1, 2, 5, 0,     0, 0, 0, 0},
    '{1, 2, 5, 16383, 0, 0, 0, 0},
    '{1, 1, 6, 1001,  0, 0, 0, 0},
    '{1, 2, 7, 3,     0, 0, 0, 0},
    '{1, 3, 5, 521,   0, 0, 0, 0},
    '{0, 0, 5, 100,   0, 0, 0, 0},
    '{0, 2, 5, 8191,  0, 0, 0, 0}
  };

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        in_tvalid = 1'b0;
  logic                        in_tready;
  logic [15:0]                 in_tdata = '0;     // [13:0] time_shift
  logic                        out_tvalid;
  logic                        out_tready = 1'b0;
  logic [31:0]                 out_tdata;         // [9:0] pre_count, [23:10] post_count,
                                                  // [30:24] phase_offset
  logic                        cfg_psel = 1'b0;
  logic                        cfg_penable = 1'b0;
  logic                        cfg_pwrite = 1'b0;
  logic [twc_pkg::CFG_AW-1:0]  cfg_paddr = '0;
  logic [twc_pkg::CFG_DW-1:0]  cfg_pwdata = '0;
  logic [twc_pkg::CFG_DW-1:0]  cfg_prdata;
  logic                        cfg_pready;

  // model state
  logic       mode_q;
  logic [1:0] pos_q;
  logic [2:0] tb_q;
  logic [6:0] phase_q;

  twc_pkg::result_t pending_counts [$];
  int      error_count;
  int      shifts_sent;
  int      results_checked;
  int      settings_applied;
  int      stall_cycles;
  int      tx_idle_pct;
  int      rx_idle_pct = 0;
  int      hold_requests = 0;
  int      hold_seen;
  int      hold_left;

  trigger_window_counts_top i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic int clamp_int(input int v, input int lo, input int hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic twc_pkg::result_t predict_counts(input logic [13:0] shift);
    int               t, k, s, q, m, pre, post, pos, tb;
    twc_pkg::result_t r;
    t   = int'(shift);
    pos = (pos_q > 2'd2) ? 2 : int'(pos_q);
    tb  = (tb_q > 3'd5) ? 5 : int'(tb_q);
    if (mode_q == ACQ_REALTIME) begin
      k    = REAL_OFFSET[pos];
      pre  = clamp_int(k - t + 511, 1, 500);
      post = 16383 - clamp_int(t - k + 10, 10, 16383);
    end else begin
      s       = RAND_STEP[tb];
      q       = t / s;
      phase_q = 7'(t - q * s);
      m       = RAND_OFFSET[tb][pos] - q + 512 / s;
      post    = 16381 - clamp_int(511 - m, 10, 16383);
      pre     = clamp_int(m, 1, 512);
    end
    if (post <= 0) post = 1;
    r.pre   = 10'(pre);
    r.post  = 14'(post);
    r.phase = phase_q;
    return r;
  endfunction

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      error_count++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endfunction

  // setup then access; the register takes the value at the access edge
  task automatic cfg_write(input logic [1:0] idx, input logic [31:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    case (idx)
      twc_pkg::REG_MODE: mode_q = value[0];
      twc_pkg::REG_POS:  pos_q  = value[1:0];
      twc_pkg::REG_TB:   tb_q   = value[2:0];
      default: ;
    endcase
  endtask

  // read back one register and compare with the model copy
  task automatic cfg_readback(input logic [1:0] idx, input int want);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= {idx, 2'b00};
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    if (int'(cfg_prdata) != want) begin
      error_count++;
      $display("%0t: register %0d readback mismatch, expected %0d, got %0d",
               $time, idx, want, cfg_prdata);
    end
  endtask

  task automatic cfg_release();
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  // registers change only once every pending result has come back
  task automatic apply_settings(input logic mode, input logic [1:0] pos, input logic [2:0] tb);
    in_tvalid <= 1'b0;
    while (pending_counts.size() != 0) @(posedge clk);
    cfg_write(twc_pkg::REG_MODE, ($urandom() & ~32'h1) | 32'(mode));
    cfg_write(twc_pkg::REG_POS,  ($urandom() & ~32'h3) | 32'(pos));
    cfg_write(twc_pkg::REG_TB,   ($urandom() & ~32'h7) | 32'(tb));
    cfg_readback(twc_pkg::REG_MODE, int'(mode_q));
    cfg_readback(twc_pkg::REG_POS,  int'(pos_q));
    cfg_readback(twc_pkg::REG_TB,   int'(tb_q));
    cfg_release();
    settings_applied++;
  endtask

  task automatic send_shift(input logic [13:0] shift, input bit typed,
                            input twc_pkg::result_t typed_counts);
    twc_pkg::result_t predicted;
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {2'b00, shift};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predicted = predict_counts(shift);
    pending_counts.push_back(typed ? typed_counts : predicted);
    shifts_sent++;
  endtask

  task automatic set_idling(input int phase);
    case (phase)
      0:       begin tx_idle_pct = 38; rx_idle_pct <= 65; end
      1:       begin tx_idle_pct = 65; rx_idle_pct <= 38; end
      default: begin tx_idle_pct = 0;  rx_idle_pct <= 0;  end
    endcase
  endtask

  // receiver: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (hold_requests != hold_seen) begin
      hold_seen = hold_requests;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left--;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  always @(posedge clk) begin : result_monitor
    twc_pkg::result_t got, want;
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_psel && cfg_penable))
        stall_cycles = 0;
      else
        stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
        $display("Test completed with failures");
        $finish;
      end
      if (out_tvalid && out_tready) begin
        got = out_tdata[30:0];
        if (pending_counts.size() == 0) begin
          error_count++;
          $display("%0t: unexpected result, expected none, got pre %0d post %0d phase %0d",
                   $time, got.pre, got.post, got.phase);
        end else begin
          want = pending_counts.pop_front();
          check_field("pre_count", int'(want.pre), int'(got.pre));
          check_field("post_count", int'(want.post), int'(got.post));
          check_field("phase_offset", int'(want.phase), int'(got.phase));
        end
        results_checked++;
      end
    end
  end

  initial begin : stimulus
    shift_row_t  row;
    logic [13:0] shift;
    mode_q = 1'b0;
    pos_q  = 2'd0;
    tb_q   = 3'd0;
    phase_q = 7'd0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    set_idling(0);

    // a write to the unused slot must leave every register alone
    cfg_write(REG_UNUSED, 32'hffff_ffff);
    cfg_release();

    foreach (SHIFT_ROWS[i]) begin
      row = SHIFT_ROWS[i];
      if (row.mode != mode_q || row.pos != pos_q || row.tb != tb_q)
        apply_settings(row.mode, row.pos, row.tb);
      send_shift(row.shift, row.typed, '{phase: row.phase, post: row.post, pre: row.pre});
    end

    for (int seg = 0; seg < SEGMENTS; seg++) begin
      set_idling(seg / 3);
      case (seg)
        0:       apply_settings(ACQ_RANDOM, 2'd2, 3'd5);
        1:       apply_settings(ACQ_REALTIME, 2'd0, 3'd0);
        2:       apply_settings(ACQ_RANDOM, 2'd0, 3'd0);
        default: apply_settings(1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)),
                                3'($urandom_range(0, 7)));
      endcase
      // sender keeps going while the output is held off, so the pipe fills
      if (seg == 6) hold_requests <= hold_requests + 1;
      for (int n = 0; n < SEG_ITEMS; n++) begin
        case ($urandom_range(0, 7))
          0:       shift = 14'h3fff - 14'($urandom_range(0, 15));
          1:       shift = 14'($urandom_range(0, 15));
          2:       shift = 14'($urandom_range(0, 1100));  // real-time clamp edges
          default: shift = 14'($urandom());
        endcase
        send_shift(shift, 1'b0, '0);
      end
    end

    in_tvalid <= 1'b0;
    while (pending_counts.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    $display("covered %0d time shifts over %0d register settings, both modes, all positions",
             shifts_sent, settings_applied);
    $display("and timebases incl. out-of-range codes; %0d results checked, %0d mismatches",
             results_checked, error_count);
    if (error_count == 0 && pending_counts.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+design
design/twc_pkg.sv
design/twc_calc.sv
design/trigger_window_counts_top.sv
design/twc_checker.sv
verif/testbench.sv
